// ===== hdl/cle_pkg.sv =====
// Shared constants, key and action codes, and the command and status structs
// of the console line editor. Used by every other file of the block but cle_ram.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int LINE_CAP     = BUFFER_DEPTH - 2;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);

   // Field widths of a result transaction.
   localparam int BYTE_W    = 8;
   localparam int ACTION_W  = 3;
   localparam int ERASE_W   = 7;
   localparam int LINE_LEN_W = 6;

   // Received key codes.
   localparam logic [BYTE_W-1:0] KEY_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] KEY_CTRL_C = 8'h03;
   localparam logic [BYTE_W-1:0] KEY_BS     = 8'h08;
   localparam logic [BYTE_W-1:0] KEY_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] KEY_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] KEY_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] KEY_CTRL_U = 8'h15;
   localparam logic [BYTE_W-1:0] KEY_CTRL_W = 8'h17;
   localparam logic [BYTE_W-1:0] KEY_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] KEY_DEL    = 8'h7F;

   // Echo actions.
   localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ECHO   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SPACES = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_BELL   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CRLF   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd5;

   // Key classes, decoded in the datapath.
   localparam int KC_W = 3;
   localparam logic [KC_W-1:0] KC_PLAIN  = 3'd0;
   localparam logic [KC_W-1:0] KC_NUL    = 3'd1;
   localparam logic [KC_W-1:0] KC_COMMIT = 3'd2;
   localparam logic [KC_W-1:0] KC_CTRLC  = 3'd3;
   localparam logic [KC_W-1:0] KC_KILL   = 3'd4;
   localparam logic [KC_W-1:0] KC_WORD   = 3'd5;
   localparam logic [KC_W-1:0] KC_ERASE  = 3'd6;
   localparam logic [KC_W-1:0] KC_TAB    = 3'd7;

   // Kinds of result the output register can be loaded with.
   localparam int OK_W = 4;
   localparam logic [OK_W-1:0] OUT_ECHO       = 4'd0;
   localparam logic [OK_W-1:0] OUT_SPACES     = 4'd1;
   localparam logic [OK_W-1:0] OUT_BELL       = 4'd2;
   localparam logic [OK_W-1:0] OUT_INTR       = 4'd3;
   localparam logic [OK_W-1:0] OUT_ERASE_ALL  = 4'd4;
   localparam logic [OK_W-1:0] OUT_ERASE_ONE  = 4'd5;
   localparam logic [OK_W-1:0] OUT_ERASE_WORD = 4'd6;
   localparam logic [OK_W-1:0] OUT_LINE_EMPTY = 4'd7;
   localparam logic [OK_W-1:0] OUT_LINE_BYTE  = 4'd8;

   // Number of store writes a TAB makes: three spaces, then the tab.
   localparam int TAB_WRITES = 4;

   typedef struct packed {
      logic            byte_load;
      logic            fill_clear;
      logic            fill_inc;
      logic            fill_dec;
      logic            idx_clear;
      logic            idx_inc;
      logic            erase_init;
      logic            erase_inc;
      logic            wr_en;
      logic            wr_tab;
      logic            rd_en;
      logic            rd_word;
      logic            out_load;
      logic [OK_W-1:0] out_kind;
   } cle_cmd_type;

   typedef struct packed {
      logic [KC_W-1:0] key_class;
      logic            fill_zero;
      logic            room_byte;
      logic            room_tab;
      logic            rd_space;
      logic            commit_last;
      logic            tab_last;
      logic            out_free;
   } cle_status_type;

endpackage

`default_nettype wire

// ===== hdl/cle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the line store of the console line editor.
`timescale 1ns / 1ps
`default_nettype none

module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/cle_datapath.sv =====
// Datapath of the console line editor: received byte, fill count, index and
// erase counters, the line store RAM and the result register. Uses cle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cle_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [cle_pkg::BYTE_W-1:0]       req_rx_byte,
   input  wire cle_pkg::cle_cmd_type             cmd,
   output cle_pkg::cle_status_type               status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [cle_pkg::ACTION_W-1:0]          rsp_echo_action,
   output logic [cle_pkg::BYTE_W-1:0]            rsp_echo_char,
   output logic [cle_pkg::ERASE_W-1:0]           rsp_erase_count,
   output logic                                  rsp_interrupt_flag,
   output logic                                  rsp_line_valid,
   output logic [cle_pkg::BYTE_W-1:0]            rsp_line_byte,
   output logic [cle_pkg::LINE_LEN_W-1:0]        rsp_line_length,
   output logic                                  rsp_last
);

   logic [cle_pkg::BYTE_W-1:0]     byte_ff;
   logic [cle_pkg::COUNT_W-1:0]    fill_ff, fill_in;
   logic [cle_pkg::ADDR_W-1:0]     idx_ff, idx_in;
   logic [cle_pkg::ERASE_W-1:0]    erase_ff, erase_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [cle_pkg::ACTION_W-1:0]   action_ff, action_in;
   logic [cle_pkg::BYTE_W-1:0]     echo_char_ff, echo_char_in;
   logic [cle_pkg::ERASE_W-1:0]    erase_count_ff, erase_count_in;
   logic                           intr_ff, intr_in;
   logic                           line_valid_ff, line_valid_in;
   logic [cle_pkg::BYTE_W-1:0]     line_byte_ff, line_byte_in;
   logic [cle_pkg::LINE_LEN_W-1:0] line_length_ff, line_length_in;
   logic                           last_ff, last_in;

   logic [cle_pkg::ADDR_W-1:0]     fill_addr;
   logic [cle_pkg::ADDR_W-1:0]     rd_addr;
   logic [cle_pkg::BYTE_W-1:0]     wr_data;
   logic [cle_pkg::BYTE_W-1:0]     rd_data;
   logic [cle_pkg::KC_W-1:0]       key_class;
   logic [cle_pkg::ERASE_W-1:0]    count_sel;
   logic                           commit_last;

   // Key decode of the captured byte.
   always_comb begin
      unique case (byte_ff) inside
         cle_pkg::KEY_CR, cle_pkg::KEY_LF:  key_class = cle_pkg::KC_COMMIT;
         cle_pkg::KEY_NUL:                  key_class = cle_pkg::KC_NUL;
         cle_pkg::KEY_CTRL_C:               key_class = cle_pkg::KC_CTRLC;
         cle_pkg::KEY_CTRL_U:               key_class = cle_pkg::KC_KILL;
         cle_pkg::KEY_CTRL_W:               key_class = cle_pkg::KC_WORD;
         cle_pkg::KEY_BS, cle_pkg::KEY_DEL: key_class = cle_pkg::KC_ERASE;
         cle_pkg::KEY_TAB:                  key_class = cle_pkg::KC_TAB;
         default:                           key_class = cle_pkg::KC_PLAIN;
      endcase
   end

   assign fill_addr   = fill_ff[cle_pkg::ADDR_W-1:0];
   assign commit_last = ({1'b0, idx_ff} + 1'b1) == fill_ff;

   // The word erase reads the byte just below the current fill count.
   assign rd_addr = cmd.rd_word ? (fill_addr - 1'b1) : idx_ff;

   // During a TAB the first three writes are spaces and the last is the tab.
   assign wr_data = (cmd.wr_tab && (idx_ff != cle_pkg::ADDR_W'(cle_pkg::TAB_WRITES - 1)))
                    ? cle_pkg::KEY_SPACE : byte_ff;

   cle_ram #(
      .WIDTH (cle_pkg::BYTE_W),
      .DEPTH (cle_pkg::BUFFER_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (fill_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.key_class   = key_class;
      status.fill_zero   = (fill_ff == '0);
      status.room_byte   = (fill_ff < cle_pkg::COUNT_W'(cle_pkg::LINE_CAP));
      status.room_tab    = ((fill_ff + cle_pkg::COUNT_W'(cle_pkg::TAB_WRITES))
                            <= cle_pkg::COUNT_W'(cle_pkg::LINE_CAP));
      status.rd_space    = (rd_data == cle_pkg::KEY_SPACE);
      status.commit_last = commit_last;
      status.tab_last    = (idx_ff == cle_pkg::ADDR_W'(cle_pkg::TAB_WRITES - 1));
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Counters.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (cmd.fill_inc) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      erase_in = erase_ff;
      if (cmd.erase_init) begin
         erase_in = {{(cle_pkg::ERASE_W-1){1'b0}}, (fill_ff != '0)};
      end else if (cmd.erase_inc) begin
         erase_in = erase_ff + 1'b1;
      end
   end

   // Result register contents.
   always_comb begin
      action_in      = cle_pkg::ACT_NONE;
      echo_char_in   = '0;
      erase_count_in = '0;
      intr_in        = 1'b0;
      line_valid_in  = 1'b0;
      line_byte_in   = '0;
      line_length_in = '0;
      last_in        = 1'b1;
      count_sel      = '0;
      case (cmd.out_kind) inside
         cle_pkg::OUT_ECHO: begin
            action_in    = cle_pkg::ACT_ECHO;
            echo_char_in = byte_ff;
         end
         cle_pkg::OUT_SPACES: action_in = cle_pkg::ACT_SPACES;
         cle_pkg::OUT_BELL:   action_in = cle_pkg::ACT_BELL;
         cle_pkg::OUT_INTR:   intr_in   = 1'b1;
         cle_pkg::OUT_ERASE_ALL, cle_pkg::OUT_ERASE_ONE, cle_pkg::OUT_ERASE_WORD: begin
            if (cmd.out_kind == cle_pkg::OUT_ERASE_ALL) begin
               count_sel = cle_pkg::ERASE_W'(fill_ff);
            end else if (cmd.out_kind == cle_pkg::OUT_ERASE_ONE) begin
               count_sel = {{(cle_pkg::ERASE_W-1){1'b0}}, (fill_ff != '0)};
            end else begin
               count_sel = erase_ff;
            end
            erase_count_in = count_sel;
            action_in      = (count_sel != '0) ? cle_pkg::ACT_ERASE : cle_pkg::ACT_NONE;
         end
         cle_pkg::OUT_LINE_EMPTY: begin
            action_in     = cle_pkg::ACT_CRLF;
            line_valid_in = 1'b1;
         end
         cle_pkg::OUT_LINE_BYTE: begin
            action_in      = (idx_ff == '0) ? cle_pkg::ACT_CRLF : cle_pkg::ACT_NONE;
            line_valid_in  = 1'b1;
            line_byte_in   = rd_data;
            line_length_in = fill_ff[cle_pkg::LINE_LEN_W-1:0];
            last_in        = commit_last;
         end
         default: begin
            action_in = cle_pkg::ACT_NONE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         idx_ff       <= '0;
         erase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         erase_ff     <= erase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_load) begin
         byte_ff <= req_rx_byte;
      end
      if (cmd.out_load) begin
         action_ff      <= action_in;
         echo_char_ff   <= echo_char_in;
         erase_count_ff <= erase_count_in;
         intr_ff        <= intr_in;
         line_valid_ff  <= line_valid_in;
         line_byte_ff   <= line_byte_in;
         line_length_ff <= line_length_in;
         last_ff        <= last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_echo_action    = action_ff;
   assign rsp_echo_char      = echo_char_ff;
   assign rsp_erase_count    = erase_count_ff;
   assign rsp_interrupt_flag = intr_ff;
   assign rsp_line_valid     = line_valid_ff;
   assign rsp_line_byte      = line_byte_ff;
   assign rsp_line_length    = line_length_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

// ===== hdl/cle_ctrl.sv =====
// Controller state machine of the console line editor. Sequences key
// handling, tab writes, line commit and word erase. Uses cle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire cle_pkg::cle_status_type status,
   output cle_pkg::cle_cmd_type         cmd
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE        = 4'd0;
   localparam logic [STATE_W-1:0] S_DECODE      = 4'd1;
   localparam logic [STATE_W-1:0] S_TAB_WR      = 4'd2;
   localparam logic [STATE_W-1:0] S_TAB_EMIT    = 4'd3;
   localparam logic [STATE_W-1:0] S_COMMIT_RD   = 4'd4;
   localparam logic [STATE_W-1:0] S_COMMIT_EMIT = 4'd5;
   localparam logic [STATE_W-1:0] S_WORD_CHECK  = 4'd6;
   localparam logic [STATE_W-1:0] S_WORD_WAIT   = 4'd7;
   localparam logic [STATE_W-1:0] S_WORD_EMIT   = 4'd8;

   logic [STATE_W-1:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.byte_load = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.key_class)
               cle_pkg::KC_NUL: state_in = S_IDLE;
               cle_pkg::KC_COMMIT: begin
                  if (!status.fill_zero) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_COMMIT_RD;
                  end else if (status.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = cle_pkg::OUT_LINE_EMPTY;
                     state_in     = S_IDLE;
                  end
               end
               cle_pkg::KC_CTRLC: begin
                  if (status.out_free) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_kind   = cle_pkg::OUT_INTR;
                     cmd.fill_clear = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               cle_pkg::KC_KILL: begin
                  if (status.out_free) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_kind   = cle_pkg::OUT_ERASE_ALL;
                     cmd.fill_clear = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               cle_pkg::KC_ERASE: begin
                  if (status.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = cle_pkg::OUT_ERASE_ONE;
                     cmd.fill_dec = !status.fill_zero;
                     state_in     = S_IDLE;
                  end
               end
               cle_pkg::KC_WORD: begin
                  // The first character goes unconditionally, space or not.
                  cmd.erase_init = 1'b1;
                  cmd.fill_dec   = !status.fill_zero;
                  state_in       = S_WORD_CHECK;
               end
               cle_pkg::KC_TAB: begin
                  if (status.room_tab) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_TAB_WR;
                  end else if (status.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = cle_pkg::OUT_BELL;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  if (status.out_free) begin
                     cmd.out_load = 1'b1;
                     if (status.room_byte) begin
                        cmd.wr_en    = 1'b1;
                        cmd.fill_inc = 1'b1;
                        cmd.out_kind = cle_pkg::OUT_ECHO;
                     end else begin
                        cmd.out_kind = cle_pkg::OUT_BELL;
                     end
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_TAB_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_tab   = 1'b1;
            cmd.fill_inc = 1'b1;
            cmd.idx_inc  = 1'b1;
            if (status.tab_last) begin
               state_in = S_TAB_EMIT;
            end
         end
         S_TAB_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = cle_pkg::OUT_SPACES;
               state_in     = S_IDLE;
            end
         end
         S_COMMIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_COMMIT_EMIT;
         end
         S_COMMIT_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = cle_pkg::OUT_LINE_BYTE;
               if (status.commit_last) begin
                  cmd.fill_clear = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_COMMIT_RD;
               end
            end
         end
         S_WORD_CHECK: begin
            if (status.fill_zero) begin
               state_in = S_WORD_EMIT;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_word = 1'b1;
               state_in    = S_WORD_WAIT;
            end
         end
         S_WORD_WAIT: begin
            if (status.rd_space) begin
               state_in = S_WORD_EMIT;
            end else begin
               cmd.fill_dec  = 1'b1;
               cmd.erase_inc = 1'b1;
               state_in      = S_WORD_CHECK;
            end
         end
         S_WORD_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = cle_pkg::OUT_ERASE_WORD;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/console_line_editor_unit.sv =====
// Console line editor top level: one received byte per transaction in, edit
// results out. Instantiates cle_ctrl and cle_datapath; uses cle_pkg.
// A single-result key loads its result once the output register is free; a TAB
// first writes three spaces and the tab to the line store. A commit does one RAM
// read and gives one result per byte; Ctrl-W erases the last character and then
// the ones before it back to a space or the start of the line. NUL gives no result.
// A new byte is taken once the previous one is finished, even while its last
// result still waits in the output register. Reset is synchronous and clears
// the state machine, fill count and result valid; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module console_line_editor_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [cle_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [cle_pkg::ACTION_W-1:0]             rsp_echo_action,
   output logic [cle_pkg::BYTE_W-1:0]               rsp_echo_char,
   output logic [cle_pkg::ERASE_W-1:0]              rsp_erase_count,
   output logic                                     rsp_interrupt_flag,
   output logic                                     rsp_line_valid,
   output logic [cle_pkg::BYTE_W-1:0]               rsp_line_byte,
   output logic [cle_pkg::LINE_LEN_W-1:0]           rsp_line_length,
   output logic                                     rsp_last
);

   cle_pkg::cle_cmd_type    cmd;
   cle_pkg::cle_status_type status;

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cle_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_action    (rsp_echo_action),
      .rsp_echo_char      (rsp_echo_char),
      .rsp_erase_count    (rsp_erase_count),
      .rsp_interrupt_flag (rsp_interrupt_flag),
      .rsp_line_valid     (rsp_line_valid),
      .rsp_line_byte      (rsp_line_byte),
      .rsp_line_length    (rsp_line_length),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire
